// ===== src/stepper_bytecode_interpreter_defines.svh =====
// Assertion macros for the stepper byte-code interpreter.
// No dependencies; included by stepper_bytecode_interpreter, which carries the assertions.
`ifndef STEPPER_BYTECODE_INTERPRETER_DEFINES_SVH
`define STEPPER_BYTECODE_INTERPRETER_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled while rst_n is low
`define SBI_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled while rst_n is low
`define SBI_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sbi_pkg.sv =====
// Types, code constants and helpers for the stepper byte-code interpreter.
// No dependencies.
package sbi_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PORT  = 3'd0,
        KIND_STALL = 3'd1,
        KIND_MODE  = 3'd2,
        KIND_EN    = 3'd3,
        KIND_SPIN  = 3'd4
    } kind_t;

    // Code byte classes and field masks
    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] SPIN_SEL_MASK  = 8'hC0;
    localparam logic [7:0] CODE_DIR       = 8'h80;
    localparam logic [7:0] CODE_STEP      = 8'h90;
    localparam logic [7:0] CODE_AUX       = 8'hA0;
    localparam logic [7:0] CODE_SPIN      = 8'hC0;
    localparam logic [7:0] DIR_BITS_MASK  = 8'h55;
    localparam logic [7:0] STEP_BITS_MASK = 8'hAA;
    localparam logic [6:0] DELAY_MASK     = 7'h7F;
    localparam logic [7:0] STATUS_SEL     = 8'h08;
    localparam logic [2:0] LOW3_MASK      = 3'h7;
    localparam logic [5:0] SPIN_MASK      = 6'h3F;

    // One decoded result
    typedef struct packed {
        logic        has;
        kind_t       kind;
        logic [7:0]  port_byte;
        logic [6:0]  stall_count;
        logic [2:0]  ustep_mode;
        logic        driver_enable;
        logic [9:0]  spindle_duty;
    } res_t;

    // Spread axis bits wzyx onto even positions 0, 2, 4, 6
    function automatic logic [7:0] spread_axes(input logic [3:0] axes);
        return {1'b0, axes[3], 1'b0, axes[2], 1'b0, axes[1], 1'b0, axes[0]};
    endfunction

endpackage

// ===== src/stepper_bytecode_interpreter.sv =====
// Stepper byte-code interpreter: input register, decode, result register.
// One code per cycle sustained unless a result code waits on a low result_ready.
// Throughput is set by the single decode stage between the two registers.
// Codes that give no result retire without waiting for the result register.
// Reset (rst_n low, asynchronous) empties both stages and clears the held port bits.
// Depends on sbi_pkg, sbi_decode and stepper_bytecode_interpreter_defines.svh.
`include "stepper_bytecode_interpreter_defines.svh"

module stepper_bytecode_interpreter
    import sbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        code_valid,
    output logic        code_ready,
    input  logic [7:0]  code_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  kind,
    output logic [7:0]  port_byte,
    output logic [6:0]  stall_count,
    output logic [2:0]  ustep_mode,
    output logic        driver_enable,
    output logic [9:0]  spindle_duty
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_code_reg;
    logic [7:0] port_bits_reg, port_bits_next;
    logic       result_valid_reg, result_valid_next;
    res_t       result_reg;
    res_t       dec_res;
    logic [7:0] dec_port_bits;
    logic       out_free;
    logic       s1_adv;
    logic       code_accept;

    // Decoder
    sbi_decode u_decode
    (
        .code          (s1_code_reg),
        .port_bits     (port_bits_reg),
        .port_bits_upd (dec_port_bits),
        .res           (dec_res)
    );

    // Stage handshakes
    assign out_free    = !result_valid_reg || result_ready;
    assign s1_adv      = s1_valid_reg && (out_free || !dec_res.has);
    assign code_ready  = !s1_valid_reg || s1_adv;
    assign code_accept = code_valid && code_ready;

    // Next-state logic
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (code_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        port_bits_next = s1_adv ? dec_port_bits : port_bits_reg;

        result_valid_next = result_valid_reg;
        if (s1_adv && dec_res.has)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            port_bits_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            port_bits_reg    <= port_bits_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (code_accept)
            s1_code_reg <= code_byte;
        if (s1_adv && dec_res.has)
            result_reg <= dec_res;
    end

    // Outputs
    assign result_valid  = result_valid_reg;
    assign kind          = result_reg.kind;
    assign port_byte     = result_reg.port_byte;
    assign stall_count   = result_reg.stall_count;
    assign ustep_mode    = result_reg.ustep_mode;
    assign driver_enable = result_reg.driver_enable;
    assign spindle_duty  = result_reg.spindle_duty;

    // Assertions
    `SBI_ASSERT_NOW(a_stall_fields, result_valid && (kind == KIND_STALL),
        (port_byte == 8'd0) && (stall_count != 7'd0), "stall result with bad fields")
    `SBI_ASSERT_NOW(a_en_fields, result_valid && (kind == KIND_EN),
        (spindle_duty == 10'd0) && (ustep_mode == 3'd0) && (port_byte == 8'd0),
        "enable result with stray fields")
    `SBI_ASSERT_NEXT(a_dir_keeps_steps,
        s1_adv && ((s1_code_reg & HI_NIBBLE_MASK) == CODE_DIR),
        (port_bits_reg & STEP_BITS_MASK) == ($past(port_bits_reg) & STEP_BITS_MASK),
        "direction code altered step bits")
    `SBI_ASSERT_NOW(a_empty_ready, !s1_valid_reg, code_ready, "empty input stage not ready")

endmodule

// ===== src/sbi_decode.sv =====
// Combinational decoder for one motion code byte.
// Depends on sbi_pkg.
module sbi_decode
    import sbi_pkg::*;
(
    input  logic [7:0] code,
    input  logic [7:0] port_bits,
    output logic [7:0] port_bits_upd,
    output res_t       res
);

    logic [7:0] axes_even;

    assign axes_even = spread_axes(code[3:0]);

    // Classify the code and build the result
    always_comb
    begin
        port_bits_upd = port_bits;
        res           = '0;
        res.kind      = KIND_PORT;
        priority if ((code & HI_NIBBLE_MASK) == CODE_STEP)
        begin
            port_bits_upd = (port_bits & DIR_BITS_MASK) | {axes_even[6:0], 1'b0};
            res.has       = 1'b1;
            res.kind      = KIND_PORT;
            res.port_byte = (port_bits & DIR_BITS_MASK) | {axes_even[6:0], 1'b0};
        end
        else if (!code[7])
        begin
            // delay; a zero count gives nothing
            res.has         = (code[6:0] & DELAY_MASK) != 7'd0;
            res.kind        = KIND_STALL;
            res.stall_count = code[6:0] & DELAY_MASK;
        end
        else if ((code & HI_NIBBLE_MASK) == CODE_DIR)
        begin
            port_bits_upd = (port_bits & STEP_BITS_MASK) | axes_even;
        end
        else if ((code & HI_NIBBLE_MASK) == CODE_AUX)
        begin
            res.has = 1'b1;
            if ((code & STATUS_SEL) != 8'd0)
            begin
                res.kind          = KIND_EN;
                res.driver_enable = (code[2:0] & LOW3_MASK) != 3'd0;
            end
            else
            begin
                res.kind       = KIND_MODE;
                res.ustep_mode = code[2:0] & LOW3_MASK;
            end
        end
        else if ((code & SPIN_SEL_MASK) == CODE_SPIN)
        begin
            res.has          = 1'b1;
            res.kind         = KIND_SPIN;
            res.spindle_duty = {code[5:0] & SPIN_MASK, 4'b0000};
        end
        else
        begin
            // undefined 1011xxxx: ignored
            res.has = 1'b0;
        end
    end

endmodule
